FILE: rtl/core/spq_pkg.sv
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int ITEM_W   = 16;
  localparam int PRIO_W   = 15;
  localparam int PIN_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int STAT_W   = 2;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [ITEM_W-1:0] item;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

FILE: rtl/core/spq_store.sv
module spq_store (
  input  logic                          clk,
  input  spq_pkg::mem_wr_t              wr,
  input  logic [spq_pkg::IDX_W-1:0]     raddr,
  output spq_pkg::entry_t               rdata
);

  spq_pkg::entry_t mem [spq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/spq_seq.sv
module spq_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     opcode,
  input  logic [spq_pkg::ITEM_W-1:0]     item_value,
  input  logic signed [spq_pkg::PIN_W-1:0] priority_in,
  output logic                           busy,
  output logic                           done,
  output logic [spq_pkg::ITEM_W-1:0]     item_out,
  output logic [spq_pkg::PRIO_W-1:0]     priority_out,
  output logic [spq_pkg::CNT_W-1:0]      cnt,
  output logic [spq_pkg::STAT_W-1:0]     status,
  output spq_pkg::mem_wr_t               wr,
  output logic [spq_pkg::IDX_W-1:0]      raddr,
  input  spq_pkg::entry_t                rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_E_RD  = 7'b0000010,
    S_E_CMP = 7'b0000100,
    S_E_INS = 7'b0001000,
    S_F_CAP = 7'b0010000,
    S_D_RD  = 7'b0100000,
    S_D_WR  = 7'b1000000
  } state_t;

  state_t                       state;
  spq_pkg::op_t                 op;
  spq_pkg::entry_t              new_entry;
  logic [spq_pkg::CNT_W-1:0]    ptr;
  logic [spq_pkg::CNT_W-1:0]    ptr_m1;
  logic [spq_pkg::CNT_W-1:0]    ptr_p1;
  logic [spq_pkg::PRIO_W-1:0]   prio_fix;
  logic                         full;
  logic                         empty;
  logic                         accept;
  logic                         shift;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (cnt == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign empty  = (cnt == '0);
  assign ptr_m1 = ptr - 1'b1;
  assign ptr_p1 = ptr + 1'b1;
  assign shift  = (new_entry.prio < rdata.prio);

  // non-positive priorities map to 1
  assign prio_fix = (priority_in[spq_pkg::PIN_W-1] || priority_in == '0) ?
                    spq_pkg::PRIO_W'(1) : priority_in[spq_pkg::PRIO_W-1:0];

  always_comb begin
    wr.en   = 1'b0;
    wr.addr = ptr[spq_pkg::IDX_W-1:0];
    wr.data = new_entry;
    raddr   = '0;
    unique case (state)
      S_E_RD: begin
        raddr = ptr_m1[spq_pkg::IDX_W-1:0];
      end
      S_E_CMP: begin
        wr.en = 1'b1;
        if (shift) begin
          wr.data = rdata;
        end
      end
      S_E_INS: begin
        wr.en = 1'b1;
      end
      S_D_RD: begin
        raddr = ptr[spq_pkg::IDX_W-1:0];
      end
      S_D_WR: begin
        wr.en   = 1'b1;
        wr.addr = ptr_m1[spq_pkg::IDX_W-1:0];
        wr.data = rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op             <= spq_pkg::op_t'(opcode);
            new_entry.item <= item_value;
            new_entry.prio <= prio_fix;
            item_out       <= '0;
            priority_out   <= '0;
            status         <= spq_pkg::ST_OK;
            ptr            <= cnt;
            unique case (spq_pkg::op_t'(opcode))
              spq_pkg::OP_ENQUEUE: begin
                if (full) begin
                  status <= spq_pkg::ST_OVERFLOW;
                  done   <= 1'b1;
                end else if (empty) begin
                  state <= S_E_INS;
                end else begin
                  state <= S_E_RD;
                end
              end
              spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
                if (empty) begin
                  status <= spq_pkg::ST_UNDERFLOW;
                  done   <= 1'b1;
                end else begin
                  state <= S_F_CAP;
                end
              end
              default: begin
                cnt  <= '0;
                done <= 1'b1;
              end
            endcase
          end
        end
        S_E_RD: begin
          state <= S_E_CMP;
        end
        S_E_CMP: begin
          if (shift) begin
            ptr   <= ptr_m1;
            state <= (ptr == spq_pkg::CNT_W'(1)) ? S_E_INS : S_E_RD;
          end else begin
            cnt   <= cnt + 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_E_INS: begin
          cnt   <= cnt + 1'b1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_F_CAP: begin
          item_out     <= rdata.item;
          priority_out <= rdata.prio;
          ptr          <= spq_pkg::CNT_W'(1);
          if (op == spq_pkg::OP_PEEK) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (cnt == spq_pkg::CNT_W'(1)) begin
            cnt   <= '0;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_D_RD;
          end
        end
        S_D_RD: begin
          state <= S_D_WR;
        end
        S_D_WR: begin
          ptr <= ptr_p1;
          if (ptr_p1 == cnt) begin
            cnt   <= cnt - 1'b1;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_D_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/stable_priority_queue.sv
// Clear, overflow, underflow finish from idle; peek captures the front; dequeue also moves
// each later entry forward (read+write per move). Enqueue moves larger-priority entries back
// one at a time; the insertion scan uses one read port, one write port and one comparator.
// Throughput: one transaction at a time; busy is high until the result cycle, when a new
// start is taken. Results are strobed by done for one cycle and cannot be stalled.
// Synchronous active-high reset empties the queue; storage contents are not cleared.
module stable_priority_queue (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode,
  input  logic [spq_pkg::ITEM_W-1:0]       item_value,
  input  logic signed [spq_pkg::PIN_W-1:0] priority_in,
  output logic                             done,
  output logic [spq_pkg::ITEM_W-1:0]       item_out,
  output logic [spq_pkg::PRIO_W-1:0]       priority_out,
  output logic [spq_pkg::COUNT_W-1:0]      count,
  output logic [spq_pkg::STAT_W-1:0]       status
);

  spq_pkg::mem_wr_t            wr;
  logic [spq_pkg::IDX_W-1:0]   raddr;
  spq_pkg::entry_t             rdata;
  logic [spq_pkg::CNT_W-1:0]   cnt;

  assign count = spq_pkg::COUNT_W'(cnt);

  spq_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .item_value   (item_value),
    .priority_in  (priority_in),
    .busy         (busy),
    .done         (done),
    .item_out     (item_out),
    .priority_out (priority_out),
    .cnt          (cnt),
    .status       (status),
    .wr           (wr),
    .raddr        (raddr),
    .rdata        (rdata)
  );

  spq_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: rtl/core/spq_checker.sv
module spq_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [1:0]                       opcode,
  input logic                             done,
  input logic [spq_pkg::ITEM_W-1:0]       item_out,
  input logic [spq_pkg::PRIO_W-1:0]       priority_out,
  input logic [spq_pkg::COUNT_W-1:0]      count,
  input logic [spq_pkg::STAT_W-1:0]       status
);

  // result cycle always leaves the block free for the next transaction
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  a_underflow_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == spq_pkg::ST_UNDERFLOW) |-> (item_out == '0 && priority_out == '0
                                                   && count == '0))
    else $error("underflow with nonzero payload");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && status == spq_pkg::ST_OVERFLOW) |->
      (count == spq_pkg::COUNT_W'(spq_pkg::CAPACITY) && item_out == '0))
    else $error("overflow while not full");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode == spq_pkg::OP_CLEAR) |=>
      (done && count == '0 && status == spq_pkg::ST_OK))
    else $error("clear did not empty queue");

  a_ok_prio: assert property (@(posedge clk) disable iff (rst)
    (done && priority_out != '0) |->
      (status == spq_pkg::ST_OK && count <= spq_pkg::COUNT_W'(spq_pkg::CAPACITY)))
    else $error("unexpected priority");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
